FILE: rtl/prof_acc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Profile accumulator package
// Shared sizes, codes, item and result layouts, and saturating helpers.
// ----------------------------------------------------------------------------
package prof_acc_pkg;

    // Store sizes
    localparam int OWNER_SLOTS  = 4096;
    localparam int SLOT_W       = $clog2(OWNER_SLOTS);
    localparam int BUCKET_COUNT = 18;
    localparam int BUCKET_AW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int HASH_SHIFT   = 4;

    // Field widths
    localparam int ACT_W    = 3;
    localparam int BIDX_W   = 5;
    localparam int ADDR_W   = 48;
    localparam int CYC_W    = 48;
    localparam int CALL_W   = 32;
    localparam int OVH_W    = 32;
    localparam int STAT_W   = 2;
    localparam int FSLOT_W  = 12;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_BUCKET_ADD  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_OWNER_ADD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BUCKET_READ = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SLOT_READ   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_ADDR = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic [FSLOT_W-1:0] slot_index;
        logic [CYC_W-1:0]   elapsed_cycles;
        logic [ADDR_W-1:0]  owner_address;
        logic [BIDX_W-1:0]  bucket_index;
        logic [ACT_W-1:0]   action;
    } item_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [CYC_W-1:0]   entry_cycles;
        logic [CALL_W-1:0]  entry_calls;
        logic [FSLOT_W-1:0] entry_slot;
        logic [ADDR_W-1:0]  entry_address;
        logic [STAT_W-1:0]  status;
    } res_t;

    // Stored entries
    typedef struct packed {
        logic [CALL_W-1:0] calls;
        logic [CYC_W-1:0]  cycles;
        logic [ADDR_W-1:0] key;
    } owner_entry_t;

    typedef struct packed {
        logic [CALL_W-1:0] calls;
        logic [CYC_W-1:0]  cycles;
    } bucket_entry_t;

    localparam int ITEM_W      = $bits(item_t);
    localparam int S_TDATA_W   = ((ITEM_W + 7) / 8) * 8;
    localparam int RES_W       = $bits(res_t);
    localparam int M_TDATA_W   = ((RES_W + 7) / 8) * 8;
    localparam int OWNER_ENT_W = $bits(owner_entry_t);
    localparam int BUCKET_ENT_W = $bits(bucket_entry_t);

    // Saturating cycle total
    function automatic logic [CYC_W-1:0] sat_add_cyc(input logic [CYC_W-1:0] a,
                                                     input logic [CYC_W-1:0] b);
        logic [CYC_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CYC_W] ? {CYC_W{1'b1}} : sum[CYC_W-1:0];
    endfunction

    // Saturating call count
    function automatic logic [CALL_W-1:0] sat_inc_call(input logic [CALL_W-1:0] a);
        return (a == {CALL_W{1'b1}}) ? a : a + CALL_W'(1);
    endfunction

endpackage

FILE: rtl/profile_accumulator_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Profile accumulator table
// Per-category totals plus a linear-probed owner table of profiling totals.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel is one command (bucket add, owner
// add, bucket read, owner slot read, clear all). Exactly one result transfer
// leaves on the m_ channel per command. cfg_wen/cfg_wdata load the timer
// overhead subtracted from every elapsed count; write it only while idle.
// The block works on one command at a time. Bucket actions and slot reads
// pass a RAM read state, then the done state loads the output register;
// rejected commands go straight to the done state. An owner add probes
// table slots, one per cycle through the owner RAM read port, up to 4096.
// Clear all sweeps the 4096-entry owner RAM one entry per cycle before it
// reports its result. The next command is accepted the cycle after the
// result is loaded into the output register, even while it waits.
// After reset the same clearing sweep runs with s_tready low.
// When the receiver stalls, the result holds in the output register and a
// following command finishes up to its last step, then waits for room.
// ----------------------------------------------------------------------------
module profile_accumulator_table
    import prof_acc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Overhead register write
    input  logic                 cfg_wen,
    input  logic [OVH_W-1:0]     cfg_wdata,
    // Command stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // action[2:0], bucket_index[7:3], owner_address[55:8],
    // elapsed_cycles[103:56], slot_index[115:104], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], entry_address[49:2], entry_slot[61:50],
    // entry_calls[93:62], entry_cycles[141:94], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_BUCKET = 3'd2;
    localparam logic [2:0] ST_PROBE  = 3'd3;
    localparam logic [2:0] ST_SLOT   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(OWNER_SLOTS - 1);

    logic [2:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                clr_action_reg, clr_action_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [ADDR_W-1:0]   key_reg, key_next;
    logic [CYC_W-1:0]    net_reg, net_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   probe_reg, probe_next;
    res_t                res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    res_t                m_data_reg, m_data_next;
    logic [OVH_W-1:0]    overhead_reg;

    item_t               in_item;
    logic [CYC_W-1:0]    net_in;
    logic                accept;
    logic                out_free;
    logic                bucket_bad;
    logic [SLOT_W-1:0]   hash_slot;

    logic                o_we;
    logic [SLOT_W-1:0]   o_waddr;
    owner_entry_t        o_wdata;
    logic [SLOT_W-1:0]   o_raddr;
    logic [OWNER_ENT_W-1:0] o_rdata_raw;
    owner_entry_t        o_rd;
    logic                b_we;
    logic [BUCKET_AW-1:0] b_waddr;
    bucket_entry_t       b_wdata;
    logic [BUCKET_AW-1:0] b_raddr;
    logic [BUCKET_ENT_W-1:0] b_rdata_raw;
    bucket_entry_t       b_rd;

    // Bucket number to RAM address; the range check happens at acceptance
    function automatic logic [BUCKET_AW-1:0] bidx_addr(input logic [BIDX_W-1:0] idx);
        return idx[BUCKET_AW-1:0];
    endfunction

    // Owner table: key, cycle total and call total in one word
    prof_acc_ram #(
        .WIDTH (OWNER_ENT_W),
        .DEPTH (OWNER_SLOTS)
    ) u_owner_ram (
        .aclk    (aclk),
        .wr_en   (o_we),
        .wr_addr (o_waddr),
        .wr_data (o_wdata),
        .rd_addr (o_raddr),
        .rd_data (o_rdata_raw)
    );

    // Category totals
    prof_acc_ram #(
        .WIDTH (BUCKET_ENT_W),
        .DEPTH (BUCKET_COUNT)
    ) u_bucket_ram (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (b_wdata),
        .rd_addr (b_raddr),
        .rd_data (b_rdata_raw)
    );

    assign o_rd = owner_entry_t'(o_rdata_raw);
    assign b_rd = bucket_entry_t'(b_rdata_raw);

    // Decode the incoming command and its net elapsed count
    assign in_item    = item_t'(s_tdata[ITEM_W-1:0]);
    assign net_in     = (in_item.elapsed_cycles > {{(CYC_W-OVH_W){1'b0}}, overhead_reg})
                      ? in_item.elapsed_cycles - {{(CYC_W-OVH_W){1'b0}}, overhead_reg}
                      : '0;
    assign bucket_bad = 32'(in_item.bucket_index) >= BUCKET_COUNT;
    assign hash_slot  = in_item.owner_address[HASH_SHIFT +: SLOT_W];
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;

    // Sequencer: read, modify, write back
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_action_next = clr_action_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        net_next        = net_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        o_we    = 1'b0;
        o_waddr = slot_reg;
        o_wdata = '0;
        o_raddr = (in_item.action == ACT_OWNER_ADD) ? hash_slot
                                                    : in_item.slot_index[SLOT_W-1:0];
        b_we    = 1'b0;
        b_waddr = bidx_addr(in_item.bucket_index);
        b_wdata = '0;
        b_raddr = bidx_addr(in_item.bucket_index);

        case (state_reg)
            // Sweep both stores to zero
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = clr_cnt_reg;
                b_we    = 32'(clr_cnt_reg) < BUCKET_COUNT;
                b_waddr = clr_cnt_reg[BUCKET_AW-1:0];
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                if (clr_cnt_reg == SLOT_MAX) begin
                    if (clr_action_reg) begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Take a command and issue the first read
            ST_IDLE: begin
                if (accept) begin
                    act_next   = in_item.action;
                    key_next   = in_item.owner_address;
                    net_next   = net_in;
                    res_next   = '0;
                    probe_next = '0;
                    case (in_item.action)
                        ACT_BUCKET_ADD, ACT_BUCKET_READ: begin
                            if (bucket_bad) begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_DONE;
                            end else begin
                                slot_next  = SLOT_W'(in_item.bucket_index);
                                state_next = ST_BUCKET;
                            end
                        end
                        ACT_OWNER_ADD: begin
                            if (in_item.owner_address == '0) begin
                                res_next.status = STAT_ZERO_ADDR;
                                state_next      = ST_DONE;
                            end else begin
                                slot_next  = hash_slot;
                                state_next = ST_PROBE;
                            end
                        end
                        ACT_SLOT_READ: begin
                            // 12-bit slot index always lies inside the table
                            slot_next  = in_item.slot_index[SLOT_W-1:0];
                            state_next = ST_SLOT;
                        end
                        ACT_CLEAR_ALL: begin
                            clr_cnt_next    = '0;
                            clr_action_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default: begin
                            res_next.status = STAT_RANGE;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end

            // Update or report one category
            ST_BUCKET: begin
                b_waddr = bidx_addr(slot_reg[BIDX_W-1:0]);
                res_next.status = STAT_OK;
                if (act_reg == ACT_BUCKET_ADD) begin
                    b_wdata.cycles = sat_add_cyc(b_rd.cycles, net_reg);
                    b_wdata.calls  = sat_inc_call(b_rd.calls);
                    b_we           = 1'b1;
                    res_next.entry_cycles = b_wdata.cycles;
                    res_next.entry_calls  = b_wdata.calls;
                end else begin
                    res_next.entry_cycles = b_rd.cycles;
                    res_next.entry_calls  = b_rd.calls;
                end
                state_next = ST_DONE;
            end

            // Probe one slot per cycle until a match, an empty slot or a full table
            ST_PROBE: begin
                o_raddr = slot_reg + SLOT_W'(1);
                if (o_rd.key == '0 || o_rd.key == key_reg) begin
                    o_wdata.key    = key_reg;
                    o_wdata.cycles = sat_add_cyc(o_rd.cycles, net_reg);
                    o_wdata.calls  = sat_inc_call(o_rd.calls);
                    o_we           = 1'b1;
                    res_next.status        = STAT_OK;
                    res_next.entry_address = key_reg;
                    res_next.entry_slot    = FSLOT_W'(slot_reg);
                    res_next.entry_calls   = o_wdata.calls;
                    res_next.entry_cycles  = o_wdata.cycles;
                    state_next = ST_DONE;
                end else if (probe_reg == SLOT_MAX) begin
                    res_next.status = STAT_FULL;
                    state_next      = ST_DONE;
                end else begin
                    slot_next  = slot_reg + SLOT_W'(1);
                    probe_next = probe_reg + SLOT_W'(1);
                end
            end

            // Report one owner slot as stored
            ST_SLOT: begin
                res_next.status        = STAT_OK;
                res_next.entry_address = o_rd.key;
                res_next.entry_slot    = FSLOT_W'(slot_reg);
                res_next.entry_calls   = o_rd.calls;
                res_next.entry_cycles  = o_rd.cycles;
                state_next = ST_DONE;
            end

            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = res_reg;
                    clr_action_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_action_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            overhead_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_action_reg <= clr_action_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wen) begin
                overhead_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        net_reg    <= net_next;
        slot_reg   <= slot_next;
        probe_reg  <= probe_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, m_data_reg};

endmodule

FILE: rtl/prof_acc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module prof_acc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: verif/profile_totals_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Profile totals checker
// Watches the command and result streams and keeps its own copy of the
// overhead register, the bucket totals and the owner table. It works out
// the result of every accepted command and compares each result transfer,
// field by field, with the oldest result still owed.
// ----------------------------------------------------------------------------
module profile_totals_checker
    import prof_acc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [OVH_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // action, bucket_index, owner_address, elapsed_cycles, slot_index, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // status, entry_address, entry_slot, entry_calls, entry_cycles, zero pad
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   outstanding
);

    logic [OVH_W-1:0]  overhead;
    logic [CYC_W-1:0]  bucket_cycles [BUCKET_COUNT];
    logic [CALL_W-1:0] bucket_calls  [BUCKET_COUNT];
    logic [ADDR_W-1:0] owner_key     [OWNER_SLOTS];
    logic [CYC_W-1:0]  owner_cycles  [OWNER_SLOTS];
    logic [CALL_W-1:0] owner_calls   [OWNER_SLOTS];
    res_t              owed_results [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Empty both stores; the overhead register is not touched
    function automatic void wipe_stores();
        int k;
        for (k = 0; k < BUCKET_COUNT; k++) begin
            bucket_cycles[k] = '0;
            bucket_calls[k]  = '0;
        end
        for (k = 0; k < OWNER_SLOTS; k++) begin
            owner_key[k]    = '0;
            owner_cycles[k] = '0;
            owner_calls[k]  = '0;
        end
    endfunction

    // Cycle total that sticks at all ones
    function automatic logic [CYC_W-1:0] cap_cycles(input logic [CYC_W-1:0] total,
                                                    input logic [CYC_W-1:0] add);
        return (add > ~total) ? {CYC_W{1'b1}} : total + add;
    endfunction

    // Call count that sticks at all ones
    function automatic logic [CALL_W-1:0] bump_calls(input logic [CALL_W-1:0] calls);
        return (&calls) ? calls : calls + 1'b1;
    endfunction

    // Update the stores for one command and return its result
    function automatic res_t apply_command(input item_t cmd);
        res_t              r;
        logic [CYC_W-1:0]  net;
        logic [SLOT_W-1:0] probe;
        int                b;
        int                n;
        bit                placed;
        r   = '0;
        b   = int'(cmd.bucket_index);
        net = (cmd.elapsed_cycles > CYC_W'(overhead)) ?
              cmd.elapsed_cycles - CYC_W'(overhead) : '0;
        case (cmd.action)
            ACT_BUCKET_ADD, ACT_BUCKET_READ: begin
                if (b >= BUCKET_COUNT) begin
                    r.status = STAT_RANGE;
                end else begin
                    if (cmd.action == ACT_BUCKET_ADD) begin
                        bucket_cycles[b] = cap_cycles(bucket_cycles[b], net);
                        bucket_calls[b]  = bump_calls(bucket_calls[b]);
                    end
                    r.status       = STAT_OK;
                    r.entry_calls  = bucket_calls[b];
                    r.entry_cycles = bucket_cycles[b];
                end
            end
            ACT_OWNER_ADD: begin
                if (cmd.owner_address == '0) begin
                    r.status = STAT_ZERO_ADDR;
                end else begin
                    // Walk from the home slot, wrapping, until a match or a hole
                    probe  = SLOT_W'(cmd.owner_address >> HASH_SHIFT);
                    placed = 1'b0;
                    for (n = 0; n < OWNER_SLOTS && !placed; n++) begin
                        if (owner_key[probe] == '0 ||
                            owner_key[probe] == cmd.owner_address) begin
                            owner_key[probe]    = cmd.owner_address;
                            owner_cycles[probe] = cap_cycles(owner_cycles[probe], net);
                            owner_calls[probe]  = bump_calls(owner_calls[probe]);
                            r.status        = STAT_OK;
                            r.entry_address = cmd.owner_address;
                            r.entry_slot    = probe;
                            r.entry_calls   = owner_calls[probe];
                            r.entry_cycles  = owner_cycles[probe];
                            placed = 1'b1;
                        end else begin
                            probe = probe + 1'b1;
                        end
                    end
                    if (!placed) r.status = STAT_FULL;
                end
            end
            ACT_SLOT_READ: begin
                if (int'(cmd.slot_index) >= OWNER_SLOTS) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.status        = STAT_OK;
                    r.entry_address = owner_key[cmd.slot_index];
                    r.entry_slot    = cmd.slot_index;
                    r.entry_calls   = owner_calls[cmd.slot_index];
                    r.entry_cycles  = owner_cycles[cmd.slot_index];
                end
            end
            ACT_CLEAR_ALL: begin
                wipe_stores();
                r.status = STAT_OK;
            end
            default: begin
                r.status = STAT_RANGE;
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    // Track config writes, predict on command transfers, check result transfers
    always @(posedge aclk) begin : watch
        item_t cmd;
        res_t  want;
        res_t  got;
        if (!aresetn) begin
            overhead = '0;
            wipe_stores();
            owed_results.delete();
        end else begin
            if (cfg_wen) overhead = cfg_wdata;
            if (s_tvalid && s_tready) begin
                cmd = item_t'(s_tdata[ITEM_W-1:0]);
                owed_results.push_back(apply_command(cmd));
            end
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[RES_W-1:0]);
                if (owed_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %0h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    compare_field("status", 64'(want.status), 64'(got.status));
                    compare_field("entry_address", 64'(want.entry_address),
                                  64'(got.entry_address));
                    compare_field("entry_slot", 64'(want.entry_slot),
                                  64'(got.entry_slot));
                    compare_field("entry_calls", 64'(want.entry_calls),
                                  64'(got.entry_calls));
                    compare_field("entry_cycles", 64'(want.entry_cycles),
                                  64'(got.entry_cycles));
                end
            end
        end
        outstanding <= owed_results.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Profile accumulator table testbench
// Drives directed and random commands through several overhead settings,
// fills the owner table to capacity, and stalls both streams at random.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import prof_acc_pkg::*;

    localparam logic [ACT_W-1:0] ACT_FIRST_UNUSED = ACT_CLEAR_ALL + 1'b1;
    localparam logic [ACT_W-1:0] ACT_LAST_UNUSED  = {ACT_W{1'b1}};
    localparam int               BIDX_MAX         = (1 << BIDX_W) - 1;
    localparam int               MAX_GAP          = 18;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wen;
    logic [OVH_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   outstanding;

    bit                   calm;
    logic [OVH_W-1:0]     ovh_now;
    logic [ADDR_W-1:0]    addr_pool [16];
    int unsigned          rx_hold;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    profile_accumulator_table i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    profile_totals_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Result side: after each transfer drop tready for a random number of cycles
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            rx_hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold != 0) m_tready <= 1'b0;
        end else if (!m_tready) begin
            if (rx_hold > 1) rx_hold--;
            else m_tready <= 1'b1;
        end
    end

    // Hold a command until it is taken, after an optional random gap
    task automatic push_command(input item_t cmd);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'(cmd);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic issue(input logic [ACT_W-1:0] act, input logic [BIDX_W-1:0] bidx,
                         input logic [ADDR_W-1:0] addr, input logic [CYC_W-1:0] elapsed,
                         input logic [FSLOT_W-1:0] slot);
        item_t c;
        c.action         = act;
        c.bucket_index   = bidx;
        c.owner_address  = addr;
        c.elapsed_cycles = elapsed;
        c.slot_index     = slot;
        push_command(c);
    endtask

    // Stop sending and wait until every owed result has been taken
    task automatic settle(input int unsigned extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic load_overhead(input logic [OVH_W-1:0] value);
        cfg_wdata <= value;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        ovh_now = value;
    endtask

    // Addresses clustered near both ends of the table, repeats, zero and random ones
    function automatic logic [ADDR_W-1:0] draw_address();
        logic [ADDR_W-1:0] a;
        logic [11:0]       home;
        int unsigned       roll;
        roll = $urandom_range(0, 99);
        home = 12'($urandom_range(0, 9)) + (($urandom_range(0, 1) != 0) ? 12'd4090 : 12'd0);
        if (roll < 3)       a = '0;
        else if (roll < 45) a = addr_pool[$urandom_range(0, 15)];
        else if (roll < 85) a = {$urandom(), home, 4'($urandom())};
        else                a = {16'($urandom()), $urandom()};
        if (roll >= 45) addr_pool[$urandom_range(0, 15)] = a;
        return a;
    endfunction

    // Elapsed counts around the overhead, small, huge and full scale
    function automatic logic [CYC_W-1:0] draw_elapsed();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)      return CYC_W'(ovh_now) + CYC_W'($urandom_range(0, 2)) - 1'b1;
        else if (roll < 50) return CYC_W'($urandom_range(0, 1000));
        else if (roll < 85) return {16'($urandom()), $urandom()};
        else if (roll < 90) return {CYC_W{1'b1}};
        else                return CYC_W'($urandom());
    endfunction

    function automatic item_t draw_command();
        item_t       c;
        int unsigned roll;
        roll = $urandom_range(0, 999);
        if (roll < 300)      c.action = ACT_BUCKET_ADD;
        else if (roll < 650) c.action = ACT_OWNER_ADD;
        else if (roll < 770) c.action = ACT_BUCKET_READ;
        else if (roll < 970) c.action = ACT_SLOT_READ;
        else if (roll < 985) c.action = ACT_CLEAR_ALL;
        else c.action = ACT_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
        if ($urandom_range(0, 9) != 0)
            c.bucket_index = BIDX_W'($urandom_range(0, BUCKET_COUNT - 1));
        else
            c.bucket_index = BIDX_W'($urandom_range(BUCKET_COUNT, BIDX_MAX));
        c.owner_address  = draw_address();
        c.elapsed_cycles = draw_elapsed();
        roll = $urandom_range(0, 9);
        if (roll < 4)      c.slot_index = FSLOT_W'($urandom_range(0, 63));
        else if (roll < 6) c.slot_index = FSLOT_W'($urandom_range(4080, 4095));
        else               c.slot_index = FSLOT_W'($urandom());
        return c;
    endfunction

    task automatic run_random(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 3) calm <= !calm;
            push_command(draw_command());
        end
    endtask

    initial begin
        logic [OVH_W-1:0]  settings [5];
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] kept_key;
        int                s;

        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        calm      = 1'b0;
        ovh_now   = '0;
        for (s = 0; s < 16; s++) addr_pool[s] = {1'b1, 15'($urandom()), $urandom()};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // Hold off until the post-reset sweep is done
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        load_overhead('0);

        // Directed: bucket extremes and saturation
        issue(ACT_BUCKET_ADD, 5'd0, '0, {CYC_W{1'b1}}, '0);
        issue(ACT_BUCKET_ADD, 5'd0, '0, 48'd5, '0);
        issue(ACT_BUCKET_ADD, BIDX_W'(BUCKET_COUNT - 1), '0, '0, '0);
        issue(ACT_BUCKET_ADD, BIDX_W'(BUCKET_COUNT), '0, 48'd9, '0);
        issue(ACT_BUCKET_READ, BIDX_W'(BIDX_MAX), '0, '0, '0);
        issue(ACT_BUCKET_READ, BIDX_W'(BUCKET_COUNT - 1), '0, '0, '0);
        // Directed: owner adds with zero key, top slot, wrap and matches
        issue(ACT_OWNER_ADD, '0, '0, 48'd3, '0);
        issue(ACT_OWNER_ADD, '0, {ADDR_W{1'b1}}, 48'd100, '0);
        issue(ACT_OWNER_ADD, '0, 48'h0000_0001_FFF0, 48'd7, '0);
        issue(ACT_OWNER_ADD, '0, {ADDR_W{1'b1}}, {CYC_W{1'b1}}, '0);
        issue(ACT_OWNER_ADD, '0, 48'h0000_0002_FFF5, 48'd11, '0);
        issue(ACT_OWNER_ADD, '0, 48'h0000_0000_0010, 48'd13, '0);
        issue(ACT_OWNER_ADD, '0, 48'h0000_0001_FFF0, 48'd17, '0);
        issue(ACT_SLOT_READ, '0, '0, '0, {FSLOT_W{1'b1}});
        issue(ACT_SLOT_READ, '0, '0, '0, 12'd0);
        issue(ACT_SLOT_READ, '0, '0, '0, 12'd2);
        issue(ACT_SLOT_READ, '0, '0, '0, 12'd100);
        // Directed: unused action codes, then clear and read back
        issue(ACT_FIRST_UNUSED, '0, '0, '0, '0);
        issue(ACT_FIRST_UNUSED + 1'b1, '0, '0, '0, '0);
        issue(ACT_LAST_UNUSED, '0, '0, '0, '0);
        issue(ACT_CLEAR_ALL, '0, '0, '0, '0);
        issue(ACT_BUCKET_READ, 5'd0, '0, '0, '0);
        issue(ACT_SLOT_READ, '0, '0, '0, {FSLOT_W{1'b1}});
        settle(20);

        // Random phases, one per overhead setting
        settings[0] = {OVH_W{1'b1}};
        settings[1] = $urandom();
        settings[2] = '0;
        settings[3] = OVH_W'($urandom_range(1, 50));
        settings[4] = $urandom();
        for (s = 0; s < 5; s++) begin
            load_overhead(settings[s]);
            run_random(240);
            settle(20);
        end

        // Fill every slot with one key per home slot, then probe a full table
        calm <= 1'b1;
        kept_key = '0;
        issue(ACT_CLEAR_ALL, '0, '0, '0, '0);
        for (s = 0; s < OWNER_SLOTS; s++) begin
            key = {1'b1, 31'($urandom()), 12'(s), 4'($urandom())};
            if (s == 7) kept_key = key;
            issue(ACT_OWNER_ADD, BIDX_W'($urandom()), key, draw_elapsed(), FSLOT_W'($urandom()));
        end
        issue(ACT_OWNER_ADD, '0, {2'b01, 30'($urandom()), 12'd7, 4'($urandom())}, 48'd1, '0);
        issue(ACT_OWNER_ADD, '0, kept_key, 48'd2, '0);
        issue(ACT_OWNER_ADD, '0, '0, 48'd3, '0);
        issue(ACT_SLOT_READ, '0, '0, '0, 12'd7);
        calm <= 1'b0;
        issue(ACT_CLEAR_ALL, '0, '0, '0, '0);
        issue(ACT_SLOT_READ, '0, '0, '0, 12'd7);
        settle(50);

        if (fail_count == 0 && outstanding == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
